// ===== hw/rtl/icaf_pkg.sv =====
// Shared types and constants for the IMU complementary attitude filter.
// Holds the sequencer state type, register indexes, the arctangent table
// and the saturation helper. No dependencies.
package icaf_pkg;

    // Arctangent table length and divider dividend width (four 16-bit digits)
    localparam int ATAN_LEN = 24;
    localparam int DIV_W    = 64;

    // Register indexes on the configuration channel
    localparam logic [2:0] REG_ACC_ROLL_OFF  = 3'd0;
    localparam logic [2:0] REG_ACC_PITCH_OFF = 3'd1;
    localparam logic [2:0] REG_GYRO_X_OFF    = 3'd2;
    localparam logic [2:0] REG_GYRO_Y_OFF    = 3'd3;
    localparam logic [2:0] REG_GYRO_Z_OFF    = 3'd4;
    localparam logic [2:0] REG_ACC_WEIGHT    = 3'd5;

    // Constant divisors and rounding biases
    localparam logic [9:0]  DIV_RATE   = 10'd131;
    localparam logic [9:0]  DIV_MS     = 10'd1000;
    localparam logic [16:0] WEIGHT_ONE = 17'd65536;

    // Reciprocals for one digit step, exact for partial dividends below 2^26
    localparam logic [26:0] RECIP_RATE    = 27'd131144040;
    localparam logic [26:0] RECIP_MS      = 27'd68719477;
    localparam int          RECIP_RATE_SH = 34;
    localparam int          RECIP_MS_SH   = 36;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RDIV_LOAD,
        ST_RDIV,
        ST_RATE,
        ST_RMUL,
        ST_DDIV_LOAD,
        ST_DDIV,
        ST_GSUM,
        ST_SQA,
        ST_SQB,
        ST_SQRT,
        ST_CORDIC_LOAD,
        ST_CORDIC,
        ST_ACC,
        ST_BM1,
        ST_BM2,
        ST_BRND,
        ST_DONE
    } state_t;

    // atan(2^-i) in degrees Q7.16, rounded to nearest
    function automatic logic signed [23:0] atan_q16(input logic [4:0] idx);
        logic signed [23:0] v;
        begin
            case (idx)
                5'd0:    v = 24'sd2949120;
                5'd1:    v = 24'sd1740967;
                5'd2:    v = 24'sd919879;
                5'd3:    v = 24'sd466945;
                5'd4:    v = 24'sd234379;
                5'd5:    v = 24'sd117304;
                5'd6:    v = 24'sd58666;
                5'd7:    v = 24'sd29335;
                5'd8:    v = 24'sd14668;
                5'd9:    v = 24'sd7334;
                5'd10:   v = 24'sd3667;
                5'd11:   v = 24'sd1833;
                5'd12:   v = 24'sd917;
                5'd13:   v = 24'sd458;
                5'd14:   v = 24'sd229;
                5'd15:   v = 24'sd115;
                5'd16:   v = 24'sd57;
                5'd17:   v = 24'sd29;
                5'd18:   v = 24'sd14;
                5'd19:   v = 24'sd7;
                5'd20:   v = 24'sd4;
                5'd21:   v = 24'sd2;
                5'd22:   v = 24'sd1;
                default: v = 24'sd0;
            endcase
            return v;
        end
    endfunction

    // Clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
        logic signed [31:0] r;
        begin
            if (v > 50'sh0_0000_7FFF_FFFF)
                r = 32'sh7FFF_FFFF;
            else if (v < -50'sh0_0000_8000_0000)
                r = 32'sh8000_0000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

// ===== hw/rtl/imu_complementary_attitude_filter.sv =====
// IMU complementary attitude filter: gyro integration, accelerometer tilt by
// integer root and CORDIC arctangent, weighted blend. Depends on icaf_pkg.
// Each input runs through six reciprocal divisions, two roots and two CORDIC passes
// before its result is loaded into the output register. One item at a time: a new
// input is taken only once the last result is loaded; that result waits in the output
// register while the next item runs. Reset (rst_n low, async): state cleared, output empty.
module imu_complementary_attitude_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    // acc_x[15:0], acc_y[31:16], acc_z[47:32], rate_x[63:48],
    // rate_y[79:64], rate_z[95:80], tick_ms[127:96]
    input  logic [127:0] s_tdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    // roll[31:0], pitch[63:32], yaw[95:64]
    output logic [95:0]  m_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [24:0]  cfg_data
);
    import icaf_pkg::*;

    localparam logic [4:0] CORDIC_LAST = 5'(CORDIC_STEPS - 1);
    localparam logic [5:0] RDIV_LAST   = 6'd3;
    localparam logic [5:0] DDIV_LAST   = 6'd7;

    // Configuration registers
    logic signed [23:0] roll_off_reg, pitch_off_reg;
    logic signed [24:0] gx_off_reg, gy_off_reg, gz_off_reg;
    logic [16:0]        weight_reg;

    // Sequencer and datapath state
    state_t             state_reg, state_next;
    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] gyro_raw_reg [3];
    logic [31:0]        dt_reg, dt_next, last_tick_reg, last_tick_next;
    logic signed [31:0] angle_reg [3];
    logic signed [31:0] angle_next [3];
    logic signed [31:0] gyro_ang_reg [2];
    logic signed [31:0] gyro_ang_next [2];
    logic signed [26:0] acc_ang_reg [2];
    logic signed [26:0] acc_ang_next [2];
    logic [1:0]         axis_reg, axis_next;
    logic               sel_reg, sel_next;
    logic [5:0]         cnt_reg, cnt_next;
    logic [DIV_W-1:0]   div_num_reg, div_num_next;
    logic [9:0]         div_rem_reg, div_rem_next;
    logic               div_neg_reg, div_neg_next;
    logic signed [25:0] rate_reg, rate_next;
    logic signed [59:0] prod_reg, prod_next;
    logic [47:0]        sq_n_reg, sq_n_next, sq_res_reg, sq_res_next;
    logic signed [27:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [24:0] cz_reg, cz_next;
    logic               zero_reg, zero_next;
    logic               out_valid_reg;
    logic [95:0]        out_data_reg;

    logic               in_take, out_load;

    // Shared multiplier
    logic signed [26:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [59:0] mul_p;

    // Helpers
    logic [16:0]        w_eff, w_comp;
    logic signed [15:0] gyro_sel;
    logic signed [16:0] gyro_ext;
    logic [16:0]        gyro_mag;
    logic signed [24:0] gyro_off_sel;
    logic signed [25:0] q_s26;
    logic signed [48:0] delta_s;
    logic [59:0]        prod_mag;
    logic [25:0]        div_x, div_back;
    logic [26:0]        div_recip;
    logic [15:0]        div_digit;
    logic signed [15:0] tilt_a;
    logic signed [16:0] tilt_num;
    logic [31:0]        sq_sum;
    logic [47:0]        sq_bit, sq_trial;
    logic signed [27:0] cx_sh, cy_sh;
    logic signed [24:0] atan_v;
    logic [43:0]        blend_q;
    logic signed [49:0] blend_s;

    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;

    assign w_eff  = (weight_reg > WEIGHT_ONE) ? WEIGHT_ONE : weight_reg;
    assign w_comp = WEIGHT_ONE - w_eff;

    assign gyro_sel = gyro_raw_reg[axis_reg];
    assign gyro_ext = 17'(gyro_sel);
    assign gyro_mag = gyro_ext[16] ? 17'(-gyro_ext) : 17'(gyro_ext);

    always_comb
    begin
        case (axis_reg)
            2'd0:    gyro_off_sel = gx_off_reg;
            2'd1:    gyro_off_sel = gy_off_reg;
            default: gyro_off_sel = gz_off_reg;
        endcase
    end

    // Signed quotients out of the divider
    assign q_s26   = div_neg_reg ? -$signed({1'b0, div_num_reg[24:0]})
                                 :  $signed({1'b0, div_num_reg[24:0]});
    assign delta_s = div_neg_reg ? -$signed({1'b0, div_num_reg[47:0]})
                                 :  $signed({1'b0, div_num_reg[47:0]});
    assign prod_mag = prod_reg[59] ? 60'(-prod_reg) : 60'(prod_reg);

    // Divider digit: reciprocal multiply, then remainder by constant multiply
    assign div_x     = {div_rem_reg, div_num_reg[DIV_W-1 -: 16]};
    assign div_recip = (state_reg == ST_RDIV) ? RECIP_RATE : RECIP_MS;
    assign div_digit = (state_reg == ST_RDIV) ? prod_reg[RECIP_RATE_SH +: 16]
                                              : prod_reg[RECIP_MS_SH +: 16];
    assign div_back  = (state_reg == ST_RDIV) ? 26'(div_digit) * 26'(DIV_RATE)
                                              : 26'(div_digit) * 26'(DIV_MS);

    // Tilt operands: roll uses (acc_y; acc_x, acc_z), pitch (-acc_x; acc_y, acc_z)
    assign tilt_a   = sel_reg ? ay_reg : ax_reg;
    assign tilt_num = sel_reg ? 17'(-17'(ax_reg)) : 17'(ay_reg);
    assign sq_sum   = 32'(prod_reg) + 32'(mul_p);

    // Integer root step
    assign sq_bit   = 48'd1 << (6'd46 - {cnt_reg[4:0], 1'b0});
    assign sq_trial = sq_res_reg + sq_bit;

    // CORDIC step
    assign cx_sh  = cx_reg >>> cnt_reg[4:0];
    assign cy_sh  = cy_reg >>> cnt_reg[4:0];
    assign atan_v = 25'(atan_q16(cnt_reg[4:0]));

    // Blend rounding, ties away from zero
    assign blend_q = 44'((prod_mag + 60'd32768) >> 16);
    assign blend_s = prod_reg[59] ? -$signed({6'd0, blend_q}) : $signed({6'd0, blend_q});

    // Multiplier operand selection
    always_comb
    begin
        case (state_reg)
            ST_RDIV, ST_DDIV:
            begin
                mul_a = $signed({1'b0, div_x});
                mul_b = $signed({6'd0, div_recip});
            end
            ST_RMUL:
            begin
                mul_a = 27'(rate_reg);
                mul_b = $signed({1'b0, dt_reg});
            end
            ST_SQA:
            begin
                mul_a = 27'(tilt_a);
                mul_b = 33'(tilt_a);
            end
            ST_SQB:
            begin
                mul_a = 27'(az_reg);
                mul_b = 33'(az_reg);
            end
            ST_BM1:
            begin
                mul_a = $signed({10'd0, w_comp});
                mul_b = 33'(gyro_ang_reg[sel_reg]);
            end
            ST_BM2:
            begin
                mul_a = $signed({10'd0, w_eff});
                mul_b = 33'(acc_ang_reg[sel_reg]);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:        if (s_tvalid) state_next = ST_RDIV_LOAD;
            ST_RDIV_LOAD:   state_next = ST_RDIV;
            ST_RDIV:        if (cnt_reg == RDIV_LAST) state_next = ST_RATE;
            ST_RATE:        state_next = ST_RMUL;
            ST_RMUL:        state_next = ST_DDIV_LOAD;
            ST_DDIV_LOAD:   state_next = ST_DDIV;
            ST_DDIV:        if (cnt_reg == DDIV_LAST) state_next = ST_GSUM;
            ST_GSUM:        state_next = (axis_reg == 2'd2) ? ST_SQA : ST_RDIV_LOAD;
            ST_SQA:         state_next = ST_SQB;
            ST_SQB:         state_next = ST_SQRT;
            ST_SQRT:        if (cnt_reg[4:0] == 5'd23) state_next = ST_CORDIC_LOAD;
            ST_CORDIC_LOAD: state_next = ST_CORDIC;
            ST_CORDIC:      if (cnt_reg[4:0] == CORDIC_LAST) state_next = ST_ACC;
            ST_ACC:         state_next = sel_reg ? ST_BM1 : ST_SQA;
            ST_BM1:         state_next = ST_BM2;
            ST_BM2:         state_next = ST_BRND;
            ST_BRND:        state_next = sel_reg ? ST_DONE : ST_BM1;
            ST_DONE:        if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:        state_next = ST_IDLE;
        endcase
    end

    // Handshake outputs
    always_comb
    begin
        s_tready = (state_reg == ST_IDLE);
        in_take  = s_tready && s_tvalid;
        out_load = (state_reg == ST_DONE) && (!out_valid_reg || m_tready);
    end

    // Datapath next values
    always_comb
    begin
        dt_next        = dt_reg;
        last_tick_next = last_tick_reg;
        angle_next     = angle_reg;
        gyro_ang_next  = gyro_ang_reg;
        acc_ang_next   = acc_ang_reg;
        axis_next      = axis_reg;
        sel_next       = sel_reg;
        cnt_next       = cnt_reg;
        div_num_next   = div_num_reg;
        div_rem_next   = div_rem_reg;
        div_neg_next   = div_neg_reg;
        rate_next      = rate_reg;
        prod_next      = prod_reg;
        sq_n_next      = sq_n_reg;
        sq_res_next    = sq_res_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cz_next        = cz_reg;
        zero_next      = zero_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    dt_next        = s_tdata[127:96] - last_tick_reg;
                    last_tick_next = s_tdata[127:96];
                    axis_next      = 2'd0;
                end
            end
            ST_RDIV_LOAD:
            begin
                div_num_next = {{gyro_mag[15:0], 16'd0} + 32'(DIV_RATE >> 1), 32'd0};
                div_neg_next = gyro_ext[16];
                div_rem_next = '0;
                cnt_next     = '0;
            end
            ST_RDIV, ST_DDIV:
            begin
                // Even cycles multiply, odd cycles take the digit and remainder
                if (!cnt_reg[0])
                begin
                    prod_next = mul_p;
                end
                else
                begin
                    div_rem_next = 10'(div_x - div_back);
                    div_num_next = {div_num_reg[DIV_W-17:0], div_digit};
                end
                cnt_next = cnt_reg + 6'd1;
            end
            ST_RATE:
            begin
                rate_next = q_s26 - 26'(gyro_off_sel);
            end
            ST_RMUL:
            begin
                prod_next = mul_p;
            end
            ST_DDIV_LOAD:
            begin
                div_num_next = DIV_W'(prod_mag) + DIV_W'(DIV_MS >> 1);
                div_neg_next = prod_reg[59];
                div_rem_next = '0;
                cnt_next     = '0;
            end
            ST_GSUM:
            begin
                if (axis_reg == 2'd2)
                begin
                    angle_next[2] = sat32(50'(angle_reg[2]) + 50'(delta_s));
                    sel_next      = 1'b0;
                end
                else
                begin
                    gyro_ang_next[axis_reg[0]] =
                        sat32(50'(angle_reg[axis_reg]) + 50'(delta_s));
                    axis_next = axis_reg + 2'd1;
                end
            end
            ST_SQA:
            begin
                prod_next = mul_p;
            end
            ST_SQB:
            begin
                sq_n_next   = {sq_sum, 16'd0};
                sq_res_next = '0;
                cnt_next    = '0;
            end
            ST_SQRT:
            begin
                if (sq_n_reg >= sq_trial)
                begin
                    sq_n_next   = sq_n_reg - sq_trial;
                    sq_res_next = (sq_res_reg >> 1) + sq_bit;
                end
                else
                begin
                    sq_res_next = sq_res_reg >> 1;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            ST_CORDIC_LOAD:
            begin
                cx_next   = $signed({4'd0, sq_res_reg[23:0]});
                cy_next   = 28'($signed({tilt_num, 8'd0}));
                cz_next   = '0;
                zero_next = (tilt_num == 17'sd0) && (sq_res_reg[23:0] == 24'd0);
                cnt_next  = '0;
            end
            ST_CORDIC:
            begin
                if (!cy_reg[27])
                begin
                    cx_next = cx_reg + cy_sh;
                    cy_next = cy_reg - cx_sh;
                    cz_next = cz_reg + atan_v;
                end
                else
                begin
                    cx_next = cx_reg - cy_sh;
                    cy_next = cy_reg + cx_sh;
                    cz_next = cz_reg - atan_v;
                end
                cnt_next = cnt_reg + 6'd1;
            end
            ST_ACC:
            begin
                acc_ang_next[sel_reg] = (zero_reg ? 27'sd0 : 27'(cz_reg))
                                      - (sel_reg ? 27'(pitch_off_reg) : 27'(roll_off_reg));
                sel_next = ~sel_reg;
            end
            ST_BM1:
            begin
                prod_next = mul_p;
            end
            ST_BM2:
            begin
                prod_next = prod_reg + mul_p;
            end
            ST_BRND:
            begin
                angle_next[sel_reg] = sat32(blend_s);
                sel_next = ~sel_reg;
            end
            default:
            begin
            end
        endcase
    end

    // Advance sequencer and hold angles
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_tick_reg <= '0;
            angle_reg[0]  <= '0;
            angle_reg[1]  <= '0;
            angle_reg[2]  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_tick_reg <= last_tick_next;
            angle_reg     <= angle_next;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            ax_reg          <= s_tdata[15:0];
            ay_reg          <= s_tdata[31:16];
            az_reg          <= s_tdata[47:32];
            gyro_raw_reg[0] <= s_tdata[63:48];
            gyro_raw_reg[1] <= s_tdata[79:64];
            gyro_raw_reg[2] <= s_tdata[95:80];
        end
        if (out_load)
            out_data_reg <= {angle_reg[2], angle_reg[1], angle_reg[0]};
        dt_reg       <= dt_next;
        gyro_ang_reg <= gyro_ang_next;
        acc_ang_reg  <= acc_ang_next;
        axis_reg     <= axis_next;
        sel_reg      <= sel_next;
        cnt_reg      <= cnt_next;
        div_num_reg  <= div_num_next;
        div_rem_reg  <= div_rem_next;
        div_neg_reg  <= div_neg_next;
        rate_reg     <= rate_next;
        prod_reg     <= prod_next;
        sq_n_reg     <= sq_n_next;
        sq_res_reg   <= sq_res_next;
        cx_reg       <= cx_next;
        cy_reg       <= cy_next;
        cz_reg       <= cz_next;
        zero_reg     <= zero_next;
    end

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_off_reg  <= 24'sd96530;
            pitch_off_reg <= -24'sd258661;
            gx_off_reg    <= -25'sd72482;
            gy_off_reg    <= -25'sd47028;
            gz_off_reg    <= -25'sd31536;
            weight_reg    <= 17'd2621;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_ACC_ROLL_OFF:  roll_off_reg  <= cfg_data[23:0];
                REG_ACC_PITCH_OFF: pitch_off_reg <= cfg_data[23:0];
                REG_GYRO_X_OFF:    gx_off_reg    <= cfg_data;
                REG_GYRO_Y_OFF:    gy_off_reg    <= cfg_data;
                REG_GYRO_Z_OFF:    gz_off_reg    <= cfg_data;
                REG_ACC_WEIGHT:    weight_reg    <= cfg_data[16:0];
                default:
                begin
                end
            endcase
        end
    end

`ifndef ASSERT_OFF
    // One transaction at a time: ready drops right after an input is taken
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an item is in progress");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RDIV || state_reg == ST_DDIV)
            |-> (div_rem_reg < ((state_reg == ST_RDIV) ? DIV_RATE : DIV_MS)))
        else $error("divider remainder out of range");

    // CORDIC x coordinate never goes negative
    a_cordic_x: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CORDIC) |-> !cx_reg[27])
        else $error("CORDIC x went negative");

    // A new result appears only out of the final state
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(state_reg == ST_DONE))
        else $error("result presented without finishing an item");
`endif

endmodule

// ===== tb/sv/imu_complementary_attitude_filter_checker.sv =====
`timescale 1ns / 1ps
// Checker for the IMU complementary attitude filter: watches the sample, result
// and configuration channels, predicts each result and compares it.
// Depends on icaf_pkg for the register indexes.
module imu_complementary_attitude_filter_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic [127:0] s_tdata,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [95:0]  m_tdata,
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [24:0]  cfg_data,
    output int           errors,
    output int           pending
);
    import icaf_pkg::*;

    typedef struct packed {
        logic signed [31:0] yaw;
        logic signed [31:0] pitch;
        logic signed [31:0] roll;
    } attitude_t;

    // atan(2^-i) in degrees Q15.16
    localparam longint ARCTAN_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    attitude_t attitude_q[$];

    // Predictor copy of registers and state
    longint          roll_bias, pitch_bias, gx_bias, gy_bias, gz_bias;
    longint unsigned blend_weight;
    longint          roll_st, pitch_st, yaw_st;
    logic [31:0]     prev_tick;

    assign pending = attitude_q.size();

    function automatic longint round_div(longint n, longint d);
        if (n >= 0)
            return (n + d / 2) / d;
        return -((-n + d / 2) / d);
    endfunction

    function automatic longint clamp32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint int_root(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b = b >> 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n = n - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return longint'(res);
    endfunction

    function automatic longint vector_angle(longint y, longint x);
        longint z;
        longint xs;
        longint ys;
        z = 0;
        if (x == 0 && y == 0)
            return 0;
        for (int i = 0; i < CORDIC_STEPS && i < 24; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + ARCTAN_DEG[i];
            end
            else
            begin
                x = x - ys;
                y = y + xs;
                z = z - ARCTAN_DEG[i];
            end
        end
        return z;
    endfunction

    function automatic longint tilt_angle(longint num, longint a, longint b);
        longint unsigned sq;
        sq = longint'(a * a + b * b);
        return vector_angle(num * 256, int_root(sq << 16));
    endfunction

    function automatic longint rate_step(longint raw, longint bias, logic [31:0] dt);
        longint rate;
        rate = round_div(raw * 65536, 131) - bias;
        return round_div(rate * longint'({32'd0, dt}), 1000);
    endfunction

    function automatic longint mix(longint gyro, longint acc, longint w);
        return clamp32(round_div((65536 - w) * gyro + w * acc, 65536));
    endfunction

    // Predict the attitude for one accepted sample and advance the state
    function automatic attitude_t predict_attitude(logic [127:0] d);
        longint      ax, ay, az, gx, gy, gz, w, g_roll, g_pitch, a_roll, a_pitch;
        logic [31:0] dt;
        attitude_t   r;
        ax = longint'($signed(d[15:0]));
        ay = longint'($signed(d[31:16]));
        az = longint'($signed(d[47:32]));
        gx = longint'($signed(d[63:48]));
        gy = longint'($signed(d[79:64]));
        gz = longint'($signed(d[95:80]));
        dt = d[127:96] - prev_tick;
        prev_tick = d[127:96];
        w = (blend_weight > 65536) ? 65536 : longint'(blend_weight);
        g_roll  = clamp32(roll_st + rate_step(gx, gx_bias, dt));
        g_pitch = clamp32(pitch_st + rate_step(gy, gy_bias, dt));
        yaw_st  = clamp32(yaw_st + rate_step(gz, gz_bias, dt));
        a_roll  = tilt_angle(ay, ax, az) - roll_bias;
        a_pitch = tilt_angle(-ax, ay, az) - pitch_bias;
        roll_st  = mix(g_roll, a_roll, w);
        pitch_st = mix(g_pitch, a_pitch, w);
        r.roll  = roll_st[31:0];
        r.pitch = pitch_st[31:0];
        r.yaw   = yaw_st[31:0];
        return r;
    endfunction

    // Follow the channels and compare results with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        attitude_t got;
        attitude_t want;
        if (!rst_n)
        begin
            roll_bias    = 96530;
            pitch_bias   = -258661;
            gx_bias      = -72482;
            gy_bias      = -47028;
            gz_bias      = -31536;
            blend_weight = 2621;
            roll_st      = 0;
            pitch_st     = 0;
            yaw_st       = 0;
            prev_tick    = '0;
            errors       = 0;
            attitude_q.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ACC_ROLL_OFF:  roll_bias  = longint'($signed(cfg_data[23:0]));
                    REG_ACC_PITCH_OFF: pitch_bias = longint'($signed(cfg_data[23:0]));
                    REG_GYRO_X_OFF:    gx_bias    = longint'($signed(cfg_data));
                    REG_GYRO_Y_OFF:    gy_bias    = longint'($signed(cfg_data));
                    REG_GYRO_Z_OFF:    gz_bias    = longint'($signed(cfg_data));
                    REG_ACC_WEIGHT:    blend_weight = {47'd0, cfg_data[16:0]};
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                attitude_q.push_back(predict_attitude(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = m_tdata;
                if (attitude_q.size() == 0)
                begin
                    $error("unexpected result transaction %h", m_tdata);
                    errors++;
                end
                else
                begin
                    want = attitude_q.pop_front();
                    if (got.roll !== want.roll)
                    begin
                        $error("roll: expected %0d, got %0d", want.roll, got.roll);
                        errors++;
                    end
                    if (got.pitch !== want.pitch)
                    begin
                        $error("pitch: expected %0d, got %0d", want.pitch, got.pitch);
                        errors++;
                    end
                    if (got.yaw !== want.yaw)
                    begin
                        $error("yaw: expected %0d, got %0d", want.yaw, got.yaw);
                        errors++;
                    end
                end
            end
        end
    end

endmodule

// ===== tb/sv/imu_complementary_attitude_filter_tb.sv =====
`timescale 1ns / 1ps
// Top of the attitude filter testbench: clock, reset, sample and register
// stimulus and the verdict. Depends on icaf_pkg, the block and its checker.
module imu_complementary_attitude_filter_tb;
    import icaf_pkg::*;

    localparam int     ITEMS_PER_PHASE = 270;
    localparam longint CYCLE_LIMIT     = 4000000;

    logic         clk;
    logic         rst_n;
    logic [127:0] s_tdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [95:0]  m_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_index;
    logic [24:0]  cfg_data;
    int           errors;
    int           pending;
    int           gap_pct;
    int           stall_pct;
    longint       cycles;
    logic [31:0]  tick_now;

    imu_complementary_attitude_filter dut (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    imu_complementary_attitude_filter_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .errors(errors), .pending(pending)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // Stall the result channel at random
    always @(negedge clk)
        m_tready = ($urandom_range(99) >= stall_pct);

    // Abort a run that hangs
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("imu_complementary_attitude_filter_tb: done, errors");
            $finish;
        end
    end

    // Offer one sample, with an optional gap before it
    task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz,
                               input logic [31:0] tick);
        if ($urandom_range(99) < gap_pct)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {tick, gz, gy, gx, az, ay, ax};
        tick_now = tick;
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
    endtask

    // Write one register once every result is out
    task automatic write_reg(input logic [2:0] idx, input logic [24:0] val);
        s_tvalid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [24:0] rand_signed(int lim);
        return 25'($signed($urandom_range(2 * lim)) - lim);
    endfunction

    // Load a random setting, pinned to an extreme now and then
    task automatic random_setting();
        write_reg(REG_ACC_ROLL_OFF,  ($urandom_range(3) == 0) ? 25'(-5898240)
                                                               : rand_signed(5898240));
        write_reg(REG_ACC_PITCH_OFF, ($urandom_range(3) == 0) ? 25'(5898240)
                                                               : rand_signed(5898240));
        write_reg(REG_GYRO_X_OFF, rand_signed(16384000));
        write_reg(REG_GYRO_Y_OFF, ($urandom_range(3) == 0) ? 25'(16384000)
                                                            : rand_signed(16384000));
        write_reg(REG_GYRO_Z_OFF, ($urandom_range(3) == 0) ? 25'(-16384000)
                                                            : rand_signed(16384000));
        write_reg(REG_ACC_WEIGHT, ($urandom_range(4) == 0) ? 25'($urandom_range(65536, 131071))
                                                            : 25'($urandom_range(65536)));
    endtask

    task automatic random_sample();
        logic signed [15:0] r [3];
        logic [31:0]        t;
        for (int i = 0; i < 3; i++)
            r[i] = ($urandom_range(4) == 0) ? 16'($urandom)
                                            : 16'($signed($urandom_range(4000)) - 2000);
        // Mostly a steady sample clock, sometimes a jump anywhere
        t = ($urandom_range(19) == 0) ? $urandom : tick_now + $urandom_range(1, 20);
        send_sample(16'($urandom), 16'($urandom), 16'($urandom), r[0], r[1], r[2], t);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        gap_pct   = 0;
        stall_pct = 0;
        cycles    = 0;
        tick_now  = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: first sample takes dt from zero, zero vector, field extremes
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd1000);
        send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF,
                    32'd1010);
        send_sample(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
                    32'd1020);
        send_sample(16'sh8000, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd1021);
        send_sample(16'sd0, 16'sh7FFF, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'd1022);
        send_sample(16'sd0, 16'sd0, 16'sd16384, 16'sd131, -16'sd131, 16'sd0, 32'd1023);
        // Tick wraps below the previous one
        send_sample(16'sd100, -16'sd200, 16'sd16000, 16'sd50, 16'sd60, 16'sd70, 32'd5);
        // Gyro only, huge dt drives the angles into saturation
        write_reg(REG_ACC_WEIGHT, 25'd0);
        write_reg(REG_GYRO_X_OFF, 25'(16384000));
        write_reg(REG_GYRO_Y_OFF, 25'(-16384000));
        write_reg(REG_GYRO_Z_OFF, 25'(-16384000));
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sh7FFF, 16'sh7FFF, 32'h7FFF_FFFE);
        send_sample(16'sd0, 16'sd0, 16'sd0, 16'sh7FFF, 16'sh8000, 16'sh8000, 32'h7FFF_FFFD);
        // Accelerometer only, offsets at their extremes
        write_reg(REG_ACC_WEIGHT, 25'd65536);
        write_reg(REG_ACC_ROLL_OFF, 25'(5898240));
        write_reg(REG_ACC_PITCH_OFF, 25'(-5898240));
        send_sample(16'sh7FFF, 16'sh8000, -16'sd1, 16'sd0, 16'sd0, 16'sd0, 32'h7FFF_FFFE);
        send_sample(-16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 32'h8000_0000);
        // Weight above one, unknown register indexes ignored
        write_reg(REG_ACC_WEIGHT, 25'h1FFFFFF);
        write_reg(3'd6, 25'h1555555);
        write_reg(3'd7, 25'h0AAAAAA);
        send_sample(16'sd4000, 16'sd9000, -16'sd12000, 16'sd700, -16'sd900, 16'sd33,
                    32'h8000_000A);
        write_reg(REG_ACC_WEIGHT, 25'd65537);
        send_sample(-16'sd4000, -16'sd9000, 16'sd12000, -16'sd700, 16'sd900, -16'sd33,
                    32'h8000_0014);

        // Random phases: no idling, sender gaps, receiver stalls, both
        for (int ph = 0; ph < 4; ph++)
        begin
            gap_pct   = (ph == 1) ? 53 : (ph == 3) ? 20 : 0;
            stall_pct = (ph == 2) ? 53 : (ph == 3) ? 20 : 0;
            random_setting();
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                random_sample();
                if (n == ITEMS_PER_PHASE / 2)
                    write_reg(REG_ACC_WEIGHT, 25'($urandom_range(65536)));
            end
        end
        s_tvalid = 1'b0;

        // Drain, then allow the block to settle
        while (pending != 0)
            @(negedge clk);
        repeat (500) @(negedge clk);
        if (errors == 0)
            $display("imu_complementary_attitude_filter_tb: done, clean");
        else
            $display("imu_complementary_attitude_filter_tb: done, errors");
        $finish;
    end

endmodule
